// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication property
`define TMH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("timer heap assertion failed");

// Next-cycle implication: ante |=> cons
`define TMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer heap assertion failed");

`endif

// ===== sv/tmh_pkg.sv =====
// ----------------------------------------------------------------------------
// tmh_pkg
// Types and codes shared by the timer event heap modules.
// ----------------------------------------------------------------------------
package tmh_pkg;

  localparam int FIELD_TIME_W = 48;
  localparam int ID_W         = 16;
  localparam int HANDLE_W     = 16;
  localparam int KIND_W       = 3;
  localparam int MODE_W       = 2;
  localparam int MAX_FIRE     = 16;
  localparam int FIRE_CNT_W   = 5;

  // input modes
  localparam logic [MODE_W-1:0] MODE_SCHED_ABS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCHED_REL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIRE      = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE_DUE  = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [FIELD_TIME_W-1:0] when;
    logic [FIELD_TIME_W-1:0] now;
    logic [HANDLE_W-1:0]     action_handle;
    logic [ID_W-1:0]         cancel_id;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     event_id;
    logic [HANDLE_W-1:0] fired_action;
    logic                last;
  } out_word_t;

  // comparator result
  typedef struct packed {
    logic dl_lt;
    logic dl_eq;
    logic ahead;
  } cmp_res_t;

endpackage

// ===== sv/tmh_mem.sv =====
// ----------------------------------------------------------------------------
// tmh_mem
// Heap entry storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmh_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 80
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tmh_cmp.sv =====
// ----------------------------------------------------------------------------
// tmh_cmp
// Shared ordering unit: deadline compare with identifier tie-break.
// ----------------------------------------------------------------------------
module tmh_cmp #(
  parameter int TW = 48
) (
  input  logic [TW-1:0]           a_dl,
  input  logic [tmh_pkg::ID_W-1:0] a_id,
  input  logic [TW-1:0]           b_dl,
  input  logic [tmh_pkg::ID_W-1:0] b_id,
  output tmh_pkg::cmp_res_t       res
);

  import tmh_pkg::*;

  always_comb begin
    res.dl_lt = a_dl < b_dl;
    res.dl_eq = a_dl == b_dl;
    res.ahead = res.dl_lt | (res.dl_eq & (a_id < b_id));
  end

endmodule

// ===== sv/timer_event_heap_unit.sv =====
// Schedule: the new entry climbs the heap one level at a time, plus result.
// Cancel: entries are read and checked in index order, then the match is removed.
// Fire: due roots are popped one after another, at most 16 per word.
// One word at a time; all steps run through one memory read port and one comparator.
// Synchronous active-low reset clears the count, identifier counter and sequencer;
// heap storage holds no reset value and is read only below the live count.
// ----------------------------------------------------------------------------
// timer_event_heap_unit
// Timer queue kept as a binary min-heap on (deadline, identifier), with a
// sequencer that sifts, scans and pops over many cycles.
// ----------------------------------------------------------------------------
module timer_event_heap_unit #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tmh_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tmh_pkg::out_word_t  out_word
);

  import tmh_pkg::*;

  localparam int TW = (TIME_BITS < FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam int EW = TW + ID_W + HANDLE_W;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_UP      = 16'h0002,
    S_UP_CMP  = 16'h0004,
    S_DN      = 16'h0008,
    S_DN_L    = 16'h0010,
    S_DN_R    = 16'h0020,
    S_DN_DEC  = 16'h0040,
    S_DN_END  = 16'h0080,
    S_RM      = 16'h0100,
    S_RM_LD   = 16'h0200,
    S_CN_RD   = 16'h0400,
    S_CN_CHK  = 16'h0800,
    S_FR_RD   = 16'h1000,
    S_FR_CHK  = 16'h2000,
    S_FR_END  = 16'h4000,
    S_EMIT    = 16'h8000
  } state_t;

  state_t               st_r, st_nxt, ret_r, ret_nxt;
  in_word_t             req_r, req_nxt;
  logic                 fire_r, fire_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [ID_W-1:0]      nid_r, nid_nxt;
  logic [IW-1:0]        pos_r, pos_nxt, start_r, start_nxt, bpos_r, bpos_nxt;
  logic                 bchild_r, bchild_nxt;
  logic [EW-1:0]        cur_r, cur_nxt, best_r, best_nxt, pend_ent_r, pend_ent_nxt;
  logic                 pend_r, pend_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic [FIRE_CNT_W-1:0] n_r, n_nxt;
  out_word_t            res_r, res_nxt, out_r;
  logic                 out_valid_r, out_load;

  // memory port
  logic                 we;
  logic [IW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;

  // comparator port
  logic [TW-1:0]        ca_dl, cb_dl;
  logic [ID_W-1:0]      ca_id, cb_id;
  cmp_res_t             cres;

  // address arithmetic
  logic [XW-1:0]        cnt_x, l_x, r_x;
  logic [IW-1:0]        parent;
  logic [CW-1:0]        cnt_m1;
  logic [TW:0]          rel_sum;
  logic [TW-1:0]        new_dl;
  state_t               fin_st;

  tmh_mem #(.DEPTH(CAPACITY), .AW(IW), .DW(EW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmh_cmp #(.TW(TW)) u_cmp (
    .a_dl (ca_dl),
    .a_id (ca_id),
    .b_dl (cb_dl),
    .b_id (cb_id),
    .res  (cres)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // index helpers
  assign cnt_x  = {{(XW-CW){1'b0}}, cnt_r};
  assign l_x    = {1'b0, pos_r, 1'b1};
  assign r_x    = l_x + XW'(1);
  assign parent = (pos_r - IW'(1)) >> 1;
  assign cnt_m1 = cnt_r - CW'(1);
  assign fin_st = fire_r ? S_FR_RD : S_EMIT;

  // deadline of a new entry, relative form saturates
  assign rel_sum = {1'b0, in_word.when[TW-1:0]} + {1'b0, in_word.now[TW-1:0]};
  always_comb begin
    if (in_word.mode == MODE_SCHED_REL) begin
      new_dl = rel_sum[TW] ? {TW{1'b1}} : rel_sum[TW-1:0];
    end else begin
      new_dl = in_word.when[TW-1:0];
    end
  end

  // comparator operand select
  always_comb begin
    ca_dl = rdata[EW-1 -: TW];
    ca_id = rdata[ID_W+HANDLE_W-1 -: ID_W];
    cb_dl = cur_r[EW-1 -: TW];
    cb_id = cur_r[ID_W+HANDLE_W-1 -: ID_W];
    case (st_r)
      S_UP_CMP: begin
        ca_dl = cur_r[EW-1 -: TW];
        ca_id = cur_r[ID_W+HANDLE_W-1 -: ID_W];
        cb_dl = rdata[EW-1 -: TW];
        cb_id = rdata[ID_W+HANDLE_W-1 -: ID_W];
      end
      S_DN_R: begin
        cb_dl = best_r[EW-1 -: TW];
        cb_id = best_r[ID_W+HANDLE_W-1 -: ID_W];
      end
      S_FR_CHK: begin
        cb_dl = req_r.now[TW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt       = st_r;
    ret_nxt      = ret_r;
    req_nxt      = req_r;
    fire_nxt     = fire_r;
    cnt_nxt      = cnt_r;
    nid_nxt      = nid_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    bpos_nxt     = bpos_r;
    bchild_nxt   = bchild_r;
    cur_nxt      = cur_r;
    best_nxt     = best_r;
    pend_nxt     = pend_r;
    pend_ent_nxt = pend_ent_r;
    scan_nxt     = scan_r;
    n_nxt        = n_r;
    res_nxt      = res_r;
    out_load     = 1'b0;
    we           = 1'b0;
    waddr        = pos_r;
    wdata        = cur_r;
    raddr        = '0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_word;
          ret_nxt  = S_IDLE;
          fire_nxt = (in_word.mode == MODE_FIRE);
          if (in_word.mode inside {MODE_SCHED_ABS, MODE_SCHED_REL}) begin
            if (cnt_r == CW'(CAPACITY)) begin
              res_nxt = '{KIND_FULL, '0, '0, 1'b1};
              st_nxt  = S_EMIT;
            end else begin
              cur_nxt = {new_dl, nid_r, in_word.action_handle};
              res_nxt = '{KIND_SCHEDULED, nid_r, '0, 1'b1};
              nid_nxt = nid_r + ID_W'(1);
              pos_nxt = cnt_r[IW-1:0];
              cnt_nxt = cnt_r + CW'(1);
              st_nxt  = S_UP;
            end
          end else if (in_word.mode == MODE_CANCEL) begin
            scan_nxt = '0;
            st_nxt   = S_CN_RD;
          end else begin
            n_nxt    = '0;
            pend_nxt = 1'b0;
            st_nxt   = S_FR_RD;
          end
        end
      end
      // sift up with a hole: parents move down until cur fits
      S_UP: begin
        if (pos_r == '0) begin
          we     = 1'b1;
          st_nxt = fin_st;
        end else begin
          raddr  = parent;
          st_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cres.ahead) begin
          wdata   = rdata;
          pos_nxt = parent;
          st_nxt  = S_UP;
        end else begin
          st_nxt = fin_st;
        end
      end
      // sift down: pick the earliest of cur and its children
      S_DN: begin
        if (l_x < cnt_x) begin
          raddr  = l_x[IW-1:0];
          st_nxt = S_DN_L;
        end else begin
          st_nxt = S_DN_END;
        end
      end
      S_DN_L: begin
        if (cres.ahead) begin
          best_nxt   = rdata;
          bpos_nxt   = l_x[IW-1:0];
          bchild_nxt = 1'b1;
        end else begin
          best_nxt   = cur_r;
          bchild_nxt = 1'b0;
        end
        if (r_x < cnt_x) begin
          raddr  = r_x[IW-1:0];
          st_nxt = S_DN_R;
        end else begin
          st_nxt = S_DN_DEC;
        end
      end
      S_DN_R: begin
        if (cres.ahead) begin
          best_nxt   = rdata;
          bpos_nxt   = r_x[IW-1:0];
          bchild_nxt = 1'b1;
        end
        st_nxt = S_DN_DEC;
      end
      S_DN_DEC: begin
        if (bchild_r) begin
          we      = 1'b1;
          wdata   = best_r;
          pos_nxt = bpos_r;
          st_nxt  = S_DN;
        end else begin
          st_nxt = S_DN_END;
        end
      end
      S_DN_END: begin
        // entry that never moved down may still need to move up
        if (pos_r == start_r) begin
          st_nxt = S_UP;
        end else begin
          we     = 1'b1;
          st_nxt = fin_st;
        end
      end
      // removal: last entry fills the freed slot
      S_RM: begin
        cnt_nxt = cnt_m1;
        if (pos_r == cnt_m1[IW-1:0]) begin
          st_nxt = fin_st;
        end else begin
          raddr  = cnt_m1[IW-1:0];
          st_nxt = S_RM_LD;
        end
      end
      S_RM_LD: begin
        cur_nxt   = rdata;
        start_nxt = pos_r;
        st_nxt    = S_DN;
      end
      // cancel: linear scan in index order
      S_CN_RD: begin
        if (scan_r >= cnt_r) begin
          res_nxt = '{KIND_NOT_FOUND, '0, '0, 1'b1};
          st_nxt  = S_EMIT;
        end else begin
          raddr  = scan_r[IW-1:0];
          st_nxt = S_CN_CHK;
        end
      end
      S_CN_CHK: begin
        if (rdata[ID_W+HANDLE_W-1 -: ID_W] == req_r.cancel_id) begin
          res_nxt = '{KIND_CANCELLED, req_r.cancel_id, '0, 1'b1};
          pos_nxt = scan_r[IW-1:0];
          st_nxt  = S_RM;
        end else begin
          scan_nxt = scan_r + CW'(1);
          st_nxt   = S_CN_RD;
        end
      end
      // fire: pop due roots; one popped word is held back to mark the last
      S_FR_RD: begin
        if (n_r == FIRE_CNT_W'(MAX_FIRE) || cnt_r == '0) begin
          st_nxt = S_FR_END;
        end else begin
          raddr  = '0;
          st_nxt = S_FR_CHK;
        end
      end
      S_FR_CHK: begin
        if (cres.dl_lt || cres.dl_eq) begin
          pend_nxt     = 1'b1;
          pend_ent_nxt = rdata;
          n_nxt        = n_r + FIRE_CNT_W'(1);
          pos_nxt      = '0;
          if (pend_r) begin
            res_nxt = '{KIND_FIRED, pend_ent_r[ID_W+HANDLE_W-1 -: ID_W],
                        pend_ent_r[HANDLE_W-1:0], 1'b0};
            ret_nxt = S_RM;
            st_nxt  = S_EMIT;
          end else begin
            st_nxt = S_RM;
          end
        end else begin
          st_nxt = S_FR_END;
        end
      end
      S_FR_END: begin
        if (pend_r) begin
          res_nxt = '{KIND_FIRED, pend_ent_r[ID_W+HANDLE_W-1 -: ID_W],
                      pend_ent_r[HANDLE_W-1:0], 1'b1};
        end else begin
          res_nxt = '{KIND_NONE_DUE, '0, '0, 1'b1};
        end
        ret_nxt = S_IDLE;
        st_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          st_nxt   = ret_r;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      nid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ret_r <= ret_nxt;
      cnt_r <= cnt_nxt;
      nid_r <= nid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    fire_r     <= fire_nxt;
    pos_r      <= pos_nxt;
    start_r    <= start_nxt;
    bpos_r     <= bpos_nxt;
    bchild_r   <= bchild_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    pend_ent_r <= pend_ent_nxt;
    scan_r     <= scan_nxt;
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

endmodule

// ===== sv/tmh_checker.sv =====
// ----------------------------------------------------------------------------
// tmh_checker
// Port-level checks of the timer event heap, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tmh_pkg::out_word_t out_word
);

  import tmh_pkg::*;

  logic act_ok;

  assign act_ok = (out_word.kind == KIND_FIRED) || (out_word.fired_action == '0);

  // a word in work keeps the input side closed for the next cycle
  `TMH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // result kinds stay in the defined set
  `TMH_ASSERT(a_kind_range, clk, rst_n, !out_valid || out_word.kind <= KIND_NONE_DUE)

  // only fired words carry an action handle
  `TMH_ASSERT(a_action_only_fired, clk, rst_n, !out_valid || act_ok)

  // a stalled result word is held
  `TMH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind timer_event_heap_unit tmh_checker u_tmh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
